// ----- rtl/lfc8_pkg.sv -----
package lfc8_pkg;

    // Line store geometry
    localparam int LINE_STORE_BYTES = 64;
    localparam int STORE_DEPTH      = LINE_STORE_BYTES - 1;
    localparam int FILL_W           = $clog2(LINE_STORE_BYTES);
    localparam int ADDR_W           = $clog2(STORE_DEPTH);

    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] CRC_INIT  = 8'h00;
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;

    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_MATCH    = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CRC_RD,
        ST_CRC_UPD,
        ST_JUDGE,
        ST_PUT_EMPTY,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic store;
        logic start_line;
        logic crc_step;
        logic idx_inc;
        logic judge;
        logic load_empty;
        logic load_data;
    } cmd_t;

    typedef struct packed {
        logic is_term;
        logic fill_zero;
        logic has_sfx;
        logic len_zero;
        logic idx_last;
        logic mismatch;
        logic out_free;
    } sts_t;

    // One byte of CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'h00;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            d = ch - 8'h30;
            r = {1'b1, d[3:0]};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            d = ch - 8'h37;
            r = {1'b1, d[3:0]};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            d = ch - 8'h57;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

// ----- rtl/line_framer_crc8_suffix_check_top.sv -----
// Line framer with CRC-8 suffix check.
// Input channel (in_valid/in_ready, rx_byte): one received byte per request.
// Ordinary bytes are written to a 63-entry line store, one per cycle; bytes
// past a full store are dropped. CR or LF closes a non-empty line.
// Output channel (out_valid/out_ready): one request per stored payload byte,
// with last on the final one, or a single request with has_data low when the
// line is empty after stripping or its checksum fails (status 2).
// Steps per closed line, from the terminator: a check of the "*XX" suffix,
// then, when a suffix and payload bytes are present, a CRC walk over the
// payload (RAM read, then a byte-wide CRC update, for each byte), a judge
// step, then a RAM read and an output load for each emitted byte, or a
// lone has_data-low request. The store has a single read port; receiver
// stalls hold the output loads.
// in_ready is low from the terminator until the last result is loaded.
// The last result of a line sits in the output register; while it waits, new line
// bytes are still taken. A receiver stall holds the emit step in place.
// Reset clears the fill count, the mismatch counter and the output valid;
// the store contents are not cleared and need no clearing pass.
module line_framer_crc8_suffix_check_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic        has_data,
    output logic        last,
    output logic [1:0]  status,
    output logic [15:0] error_total
);
    import lfc8_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing: accept, suffix check, CRC walk, judge, emit
    lfc8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // line store, CRC, counters and output register
    lfc8_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_byte   (data_byte),
        .has_data    (has_data),
        .last        (last),
        .status      (status),
        .error_total (error_total)
    );

endmodule

// ----- rtl/lfc8_ram.sv -----
module lfc8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lfc8_ctrl.sv -----
module lfc8_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lfc8_pkg::sts_t sts,
    output lfc8_pkg::cmd_t cmd
);
    import lfc8_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (!sts.is_term) begin
                        cmd.store = 1'b1;
                    end else if (!sts.fill_zero) begin
                        cmd.start_line = 1'b1;
                        state_next     = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sts.has_sfx && !sts.len_zero)
                    state_next = ST_CRC_RD;
                else
                    state_next = ST_JUDGE;
            end
            ST_CRC_RD:
                state_next = ST_CRC_UPD;
            ST_CRC_UPD:
            begin
                cmd.crc_step = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_JUDGE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_CRC_RD;
                end
            end
            ST_JUDGE:
            begin
                cmd.judge = 1'b1;
                if (sts.mismatch || sts.len_zero)
                    state_next = ST_PUT_EMPTY;
                else
                    state_next = ST_EMIT_RD;
            end
            ST_PUT_EMPTY:
            begin
                if (sts.out_free) begin
                    cmd.load_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT_RD:
                state_next = ST_EMIT_LD;
            ST_EMIT_LD:
            begin
                if (sts.out_free) begin
                    cmd.load_data = 1'b1;
                    if (sts.idx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/lfc8_dp.sv -----
module lfc8_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     rx_byte,
    input  lfc8_pkg::cmd_t cmd,
    output lfc8_pkg::sts_t sts,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     data_byte,
    output logic           has_data,
    output logic           last,
    output logic [1:0]     status,
    output logic [15:0]    error_total
);
    import lfc8_pkg::*;

    // control state
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       count_reg, count_next;
    logic              out_valid_reg, out_valid_next;

    // payload state
    logic [7:0]        tail0_reg, tail1_reg, tail2_reg;
    logic [FILL_W-1:0] len_reg, idx_reg;
    logic [7:0]        crc_reg, expect_reg;
    logic [1:0]        line_status_reg;
    logic [7:0]        data_byte_reg;
    logic              has_data_reg, last_reg;
    logic [1:0]        status_reg;
    logic [15:0]       error_total_reg;

    logic [7:0]        rdata;
    logic              store_en;
    logic [4:0]        hex_hi, hex_lo;
    logic              sfx_found;
    logic              mism;

    assign store_en  = cmd.store && (fill_reg < FILL_W'(STORE_DEPTH));
    assign hex_hi    = hex_decode(tail1_reg);
    assign hex_lo    = hex_decode(tail0_reg);
    assign sfx_found = (fill_reg >= FILL_W'(3)) && (tail2_reg == CHAR_STAR)
                       && hex_hi[4] && hex_lo[4];
    assign mism      = (line_status_reg == STATUS_MATCH) && (crc_reg != expect_reg);

    lfc8_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_en),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        sts.is_term   = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
        sts.fill_zero = (fill_reg == '0);
        sts.has_sfx   = (line_status_reg == STATUS_MATCH);
        sts.len_zero  = (len_reg == '0);
        sts.idx_last  = (({1'b0, idx_reg} + 1'b1) == {1'b0, len_reg});
        sts.mismatch  = mism;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (store_en)
            fill_next = fill_reg + 1'b1;
        else if (cmd.start_line)
            fill_next = '0;

        count_next = count_reg;
        if (cmd.judge && mism)
            count_next = count_reg + 1'b1;

        out_valid_next = out_valid_reg;
        if (cmd.load_empty || cmd.load_data)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // last three stored bytes, for the suffix check
        if (store_en) begin
            tail0_reg <= rx_byte;
            tail1_reg <= tail0_reg;
            tail2_reg <= tail1_reg;
        end

        if (cmd.start_line) begin
            idx_reg    <= '0;
            crc_reg    <= CRC_INIT;
            expect_reg <= {hex_hi[3:0], hex_lo[3:0]};
            if (sfx_found) begin
                len_reg         <= fill_reg - FILL_W'(3);
                line_status_reg <= STATUS_MATCH;
            end else begin
                len_reg         <= fill_reg;
                line_status_reg <= STATUS_NONE;
            end
        end

        if (cmd.crc_step)
            crc_reg <= crc8_byte(crc_reg, rdata);

        if (cmd.judge) begin
            idx_reg <= '0;
            if (mism)
                line_status_reg <= STATUS_MISMATCH;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end

        if (cmd.load_empty) begin
            data_byte_reg   <= 8'h00;
            has_data_reg    <= 1'b0;
            last_reg        <= 1'b1;
            status_reg      <= line_status_reg;
            error_total_reg <= count_reg;
        end else if (cmd.load_data) begin
            data_byte_reg   <= rdata;
            has_data_reg    <= 1'b1;
            last_reg        <= sts.idx_last;
            status_reg      <= line_status_reg;
            error_total_reg <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = data_byte_reg;
    assign has_data    = has_data_reg;
    assign last        = last_reg;
    assign status      = status_reg;
    assign error_total = error_total_reg;

endmodule
